// ===== sv/temh_pkg.sv =====
// Shared types and constants for the timed event min-heap.
package temh_pkg;

   localparam int CAPACITY     = 1024;
   localparam int PAYLOAD_BITS = 32;
   localparam int ADDR_BITS    = $clog2(CAPACITY);
   localparam int POS_BITS     = 11;
   localparam int TIME_BITS    = 64;
   localparam int PAY_PORT_BITS = 32;

   typedef enum logic [2:0] {
      CMD_INSERT  = 3'd0,
      CMD_PEEK    = 3'd1,
      CMD_EXTRACT = 3'd2,
      CMD_DELETE  = 3'd3,
      CMD_READ    = 3'd4,
      CMD_CLEAR   = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]    etime;
      logic [PAYLOAD_BITS-1:0] epay;
   } entry_type;

   // Memory access bundle from the sequencer to the heap store.
   typedef struct packed {
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      entry_type            wr_data;
   } mem_req_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_A,      // read slot A issued
      S_WAIT_A,
      S_WAIT_B,    // last slot read for a removal
      S_UP_RD,     // sift up: read parent
      S_UP_CMP,
      S_DN_RDL,    // sift down: read left child
      S_DN_RDR,
      S_DN_CMP,
      S_DN_CMP2,
      S_DONE
   } state_type;

   // Slot number (one-based) to memory address.
   function automatic logic [ADDR_BITS-1:0] slot_addr(input logic [POS_BITS-1:0] slot);
      logic [POS_BITS-1:0] s;
      s = slot - POS_BITS'(1);
      return s[ADDR_BITS-1:0];
   endfunction

   // True when the key of a is strictly below the key of b.
   function automatic logic key_less(input logic [TIME_BITS-1:0] a,
                                     input logic [TIME_BITS-1:0] b,
                                     input logic [TIME_BITS-1:0] base);
      logic signed [TIME_BITS-1:0] ka;
      logic signed [TIME_BITS-1:0] kb;
      ka = a - base;
      kb = b - base;
      return ka < kb;
   endfunction

endpackage

// ===== sv/temh_store.sv =====
// Heap entry memory: one write port and one registered read port.
module temh_store (
   input  logic                 clock,
   input  temh_pkg::mem_req_type mem_req,
   output temh_pkg::entry_type  rd_data
);

   temh_pkg::entry_type mem_ff [temh_pkg::CAPACITY];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data <= mem_ff[mem_req.rd_addr];
      end
   end

endmodule

// ===== sv/temh_ctrl.sv =====
// Command sequencer: decodes commands and walks sift-up and sift-down.
module temh_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_cmd,
   input  logic [temh_pkg::TIME_BITS-1:0]       req_event_time,
   input  logic [temh_pkg::PAY_PORT_BITS-1:0]   req_event_payload,
   input  logic [temh_pkg::POS_BITS-1:0]        req_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [temh_pkg::TIME_BITS-1:0]       rsp_found_time,
   output logic [temh_pkg::PAY_PORT_BITS-1:0]   rsp_found_payload,
   output logic [temh_pkg::POS_BITS-1:0]        rsp_entry_count,
   input  logic                                 csr_write,
   input  logic [temh_pkg::TIME_BITS-1:0]       csr_wdata,
   output temh_pkg::mem_req_type                mem_req,
   input  temh_pkg::entry_type                  rd_data
);

   localparam int PB = temh_pkg::POS_BITS;

   temh_pkg::state_type state_ff, state_in;
   logic [PB-1:0] count_ff, count_in;
   logic [temh_pkg::TIME_BITS-1:0] base_ff;
   // cur: the entry being moved and its slot; other: neighbor read from memory
   temh_pkg::entry_type cur_ff, cur_in;
   temh_pkg::entry_type left_ff, left_in;
   logic [PB-1:0] k_ff, k_in;
   logic          del_ff, del_in;   // delete: try sift up, then sift down

   logic                        rv_ff, rv_in;
   logic [1:0]                  st_ff, st_in;
   logic [temh_pkg::TIME_BITS-1:0] ft_ff, ft_in;
   logic [temh_pkg::PAY_PORT_BITS-1:0] fp_ff, fp_in;
   logic [2:0]                  op_ff, op_in;

   // Result register, so a waiting result holds up only the end of the next command.
   logic [1:0]                  out_st_ff, out_st_in;
   logic [temh_pkg::TIME_BITS-1:0] out_ft_ff, out_ft_in;
   logic [temh_pkg::PAY_PORT_BITS-1:0] out_fp_ff, out_fp_in;
   logic [PB-1:0]               out_cnt_ff, out_cnt_in;

   logic accept;
   logic rsp_free;
   logic up_less, dn_lless, dn_rless;
   logic [PB-1:0] l_slot, r_slot, p_slot;

   assign req_stall = (state_ff != temh_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rv_ff || !rsp_stall;
   assign l_slot    = {k_ff[PB-2:0], 1'b0};
   assign r_slot    = {k_ff[PB-2:0], 1'b1};
   assign p_slot    = {1'b0, k_ff[PB-1:1]};

   assign up_less  = temh_pkg::key_less(cur_ff.etime, rd_data.etime, base_ff);
   assign dn_lless = temh_pkg::key_less(left_ff.etime, cur_ff.etime, base_ff);
   assign dn_rless = (r_slot <= count_ff) &&
                     (dn_lless ? temh_pkg::key_less(rd_data.etime, left_ff.etime, base_ff)
                               : temh_pkg::key_less(rd_data.etime, cur_ff.etime, base_ff));

   assign rsp_valid         = rv_ff;
   assign rsp_status        = out_st_ff;
   assign rsp_found_time    = out_ft_ff;
   assign rsp_found_payload = out_fp_ff;
   assign rsp_entry_count   = out_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= temh_pkg::S_IDLE;
         count_ff <= '0;
         base_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
         if (csr_write) begin
            base_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      left_ff    <= left_in;
      k_ff       <= k_in;
      del_ff     <= del_in;
      st_ff      <= st_in;
      ft_ff      <= ft_in;
      fp_ff      <= fp_in;
      op_ff      <= op_in;
      out_st_ff  <= out_st_in;
      out_ft_ff  <= out_ft_in;
      out_fp_ff  <= out_fp_in;
      out_cnt_ff <= out_cnt_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         temh_pkg::S_IDLE: begin
            if (accept) begin
               state_in = temh_pkg::S_DONE;
               unique case (req_cmd)
                  temh_pkg::CMD_INSERT: begin
                     if (count_ff != PB'(temh_pkg::CAPACITY)) begin
                        state_in = temh_pkg::S_UP_RD;
                     end
                  end
                  temh_pkg::CMD_PEEK, temh_pkg::CMD_EXTRACT: begin
                     if (count_ff != '0) state_in = temh_pkg::S_RD_A;
                  end
                  temh_pkg::CMD_DELETE, temh_pkg::CMD_READ: begin
                     if (count_ff != '0 && req_position != '0 &&
                         req_position <= count_ff) begin
                        state_in = temh_pkg::S_RD_A;
                     end
                  end
                  default: state_in = temh_pkg::S_DONE;
               endcase
            end
         end
         temh_pkg::S_RD_A:   state_in = temh_pkg::S_WAIT_A;
         temh_pkg::S_WAIT_A: begin
            if (op_ff == temh_pkg::CMD_EXTRACT || op_ff == temh_pkg::CMD_DELETE) begin
               state_in = temh_pkg::S_WAIT_B;
            end else begin
               state_in = temh_pkg::S_DONE;
            end
         end
         temh_pkg::S_WAIT_B: begin
            // Removing the last slot itself leaves nothing to move.
            if (k_ff < count_ff) begin
               state_in = (op_ff == temh_pkg::CMD_DELETE) ? temh_pkg::S_UP_RD
                                                          : temh_pkg::S_DN_RDL;
            end else begin
               state_in = temh_pkg::S_DONE;
            end
         end
         temh_pkg::S_UP_RD: begin
            state_in = (k_ff <= PB'(1)) ? (del_ff ? temh_pkg::S_DN_RDL : temh_pkg::S_DONE)
                                         : temh_pkg::S_UP_CMP;
         end
         temh_pkg::S_UP_CMP: begin
            if (up_less) begin
               state_in = temh_pkg::S_UP_RD;
            end else begin
               state_in = del_ff ? temh_pkg::S_DN_RDL : temh_pkg::S_DONE;
            end
         end
         temh_pkg::S_DN_RDL: begin
            state_in = (l_slot > count_ff || k_ff[PB-1]) ? temh_pkg::S_DONE
                                                          : temh_pkg::S_DN_RDR;
         end
         temh_pkg::S_DN_RDR: state_in = temh_pkg::S_DN_CMP;
         temh_pkg::S_DN_CMP: state_in = temh_pkg::S_DN_CMP2;
         temh_pkg::S_DN_CMP2: begin
            state_in = (dn_lless || dn_rless) ? temh_pkg::S_DN_RDL : temh_pkg::S_DONE;
         end
         temh_pkg::S_DONE: begin
            if (rsp_free) state_in = temh_pkg::S_IDLE;
         end
         default: state_in = temh_pkg::S_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      count_in   = count_ff;
      cur_in     = cur_ff;
      left_in    = left_ff;
      k_in       = k_ff;
      del_in     = del_ff;
      rv_in      = rv_ff && rsp_stall;
      st_in      = st_ff;
      ft_in      = ft_ff;
      fp_in      = fp_ff;
      op_in      = op_ff;
      out_st_in  = out_st_ff;
      out_ft_in  = out_ft_ff;
      out_fp_in  = out_fp_ff;
      out_cnt_in = out_cnt_ff;
      mem_req    = '0;
      unique case (state_ff)
         temh_pkg::S_IDLE: begin
            if (accept) begin
               op_in  = req_cmd;
               st_in  = temh_pkg::ST_OK;
               ft_in  = '0;
               fp_in  = '0;
               del_in = 1'b0;
               cur_in.etime = req_event_time;
               cur_in.epay  = req_event_payload[temh_pkg::PAYLOAD_BITS-1:0];
               unique case (req_cmd)
                  temh_pkg::CMD_INSERT: begin
                     if (count_ff == PB'(temh_pkg::CAPACITY)) begin
                        st_in = temh_pkg::ST_FULL;
                     end else begin
                        count_in = count_ff + PB'(1);
                        k_in     = count_ff + PB'(1);
                     end
                  end
                  temh_pkg::CMD_PEEK, temh_pkg::CMD_EXTRACT: begin
                     if (count_ff == '0) st_in = temh_pkg::ST_EMPTY;
                     k_in = PB'(1);
                  end
                  temh_pkg::CMD_DELETE, temh_pkg::CMD_READ: begin
                     if (count_ff == '0) st_in = temh_pkg::ST_EMPTY;
                     else if (req_position == '0 || req_position > count_ff)
                        st_in = temh_pkg::ST_BADPOS;
                     k_in = req_position;
                  end
                  temh_pkg::CMD_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         temh_pkg::S_RD_A: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = temh_pkg::slot_addr(k_ff);
         end
         temh_pkg::S_WAIT_A: begin
            if (op_ff == temh_pkg::CMD_EXTRACT || op_ff == temh_pkg::CMD_DELETE) begin
               // Capture the removed entry and fetch the last one to fill the hole.
               if (op_ff == temh_pkg::CMD_EXTRACT) begin
                  ft_in = rd_data.etime;
                  fp_in = temh_pkg::PAY_PORT_BITS'(rd_data.epay);
               end
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = temh_pkg::slot_addr(count_ff);
            end else begin
               ft_in = rd_data.etime;
               fp_in = temh_pkg::PAY_PORT_BITS'(rd_data.epay);
            end
         end
         temh_pkg::S_WAIT_B: begin
            cur_in   = rd_data;
            count_in = count_ff - PB'(1);
            del_in   = (op_ff == temh_pkg::CMD_DELETE);
         end
         temh_pkg::S_UP_RD: begin
            if (k_ff > PB'(1)) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = temh_pkg::slot_addr(p_slot);
            end
         end
         temh_pkg::S_UP_CMP: begin
            if (up_less) begin
               // Parent moves down into the hole; cur goes one level up.
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = temh_pkg::slot_addr(k_ff);
               mem_req.wr_data = rd_data;
               k_in            = p_slot;
               del_in          = 1'b0;
            end
         end
         temh_pkg::S_DN_RDL: begin
            if (!(l_slot > count_ff || k_ff[PB-1])) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = temh_pkg::slot_addr(l_slot);
            end
         end
         temh_pkg::S_DN_RDR: begin
            left_in = rd_data;
            if (r_slot <= count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = temh_pkg::slot_addr(r_slot);
            end
         end
         temh_pkg::S_DN_CMP2: begin
            if (dn_rless) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = temh_pkg::slot_addr(k_ff);
               mem_req.wr_data = rd_data;
               k_in            = r_slot;
            end else if (dn_lless) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = temh_pkg::slot_addr(k_ff);
               mem_req.wr_data = left_ff;
               k_in            = l_slot;
            end
         end
         temh_pkg::S_DONE: begin
            if (rsp_free) begin
               // The moving entry settles in its final slot.
               if ((op_ff == temh_pkg::CMD_INSERT || op_ff == temh_pkg::CMD_EXTRACT ||
                    op_ff == temh_pkg::CMD_DELETE) && st_ff == temh_pkg::ST_OK &&
                   k_ff <= count_ff && k_ff != '0) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = temh_pkg::slot_addr(k_ff);
                  mem_req.wr_data = cur_ff;
               end
               rv_in      = 1'b1;
               out_st_in  = st_ff;
               out_ft_in  = ft_ff;
               out_fp_in  = fp_ff;
               out_cnt_in = count_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== sv/timed_event_min_heap.sv =====
// Top level of the timed event min-heap priority queue.
//   channel | direction | fields
//   req     | in        | cmd, event_time, event_payload, position
//   rsp     | out       | status, found_time, found_payload, entry_count
//   csr     | in        | base_time (write only)
// One command at a time; req_stall stays high from the accepting edge while
// a command reads its slots and walks sift up or sift down, until its result
// is registered; the result is valid after.
// Every sift step waits on the registered read of the heap store.
// Reset is synchronous and clears the state, count, base time and rsp_valid.
// A waiting result stalls only the end of the next command, not its transfer.
module timed_event_min_heap (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_cmd,
   input  logic [temh_pkg::TIME_BITS-1:0]     req_event_time,
   input  logic [temh_pkg::PAY_PORT_BITS-1:0] req_event_payload,
   input  logic [temh_pkg::POS_BITS-1:0]      req_position,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [temh_pkg::TIME_BITS-1:0]     rsp_found_time,
   output logic [temh_pkg::PAY_PORT_BITS-1:0] rsp_found_payload,
   output logic [temh_pkg::POS_BITS-1:0]      rsp_entry_count,
   input  logic                               csr_write,
   input  logic [temh_pkg::TIME_BITS-1:0]     csr_base_time
);

   temh_pkg::mem_req_type mem_req;
   temh_pkg::entry_type   rd_data;

   temh_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_event_time    (req_event_time),
      .req_event_payload (req_event_payload),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_found_time    (rsp_found_time),
      .rsp_found_payload (rsp_found_payload),
      .rsp_entry_count   (rsp_entry_count),
      .csr_write         (csr_write),
      .csr_wdata         (csr_base_time),
      .mem_req           (mem_req),
      .rd_data           (rd_data)
   );

   temh_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule
